/* rtl/bpe_pkg.sv */
// Branch predictor evaluator: shared payload types, opcodes and kind codes.
// No dependencies; taken in by every module of the block but bpe_queue.
`default_nettype none

package bpe_pkg;

    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_JAL    = 7'h6F;
    localparam logic [6:0] OP_JALR   = 7'h67;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_COND = 2'd1;
    localparam logic [1:0] KIND_JAL  = 2'd2;
    localparam logic [1:0] KIND_JALR = 2'd3;

    localparam int N_PRED = 6;

    typedef struct packed {
        logic [31:0] pc;
        logic [31:0] instruction;
        logic [31:0] next_pc;
    } t_in;

    typedef struct packed {
        logic [1:0]        branch_kind;
        logic              br_taken;
        logic [31:0]       branch_target;
        logic [N_PRED-1:0] prediction_mask;
        logic [N_PRED-1:0] correct_mask;
    } t_out;

    // Decoded item as it travels from front to back
    typedef struct packed {
        logic [1:0]  kind;
        logic        taken;
        logic [31:0] target;
        logic        backward;
    } t_dec;

endpackage

`default_nettype wire

/* rtl/bpe_front.sv */
// Front end: decodes one instruction beat into kind, outcome, target and table
// indices, and keeps the global history. Depends on bpe_pkg.
`default_nettype none

module bpe_front #(
    parameter int BHT_W        = 8,
    parameter int PHT_W        = 9,
    parameter int HISTORY_BITS = 9
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_accept,
    input  bpe_pkg::t_in      i_data,
    output bpe_pkg::t_dec     o_dec,
    output logic [BHT_W-1:0]  o_bi,
    output logic [PHT_W-1:0]  o_gi
);
    import bpe_pkg::*;

    logic [HISTORY_BITS-1:0] r_hist;
    logic [HISTORY_BITS-1:0] n_hist;
    logic [6:0]              op;
    logic [1:0]              kind;
    logic [31:0]             imm_b;
    logic [31:0]             imm_j;
    logic [31:0]             imm;
    logic [32:0]             sum;
    logic [29:0]             hist_x;

    assign op    = i_data.instruction[6:0];
    assign imm_b = {{19{i_data.instruction[31]}}, i_data.instruction[31],
                    i_data.instruction[7], i_data.instruction[30:25],
                    i_data.instruction[11:8], 1'b0};
    assign imm_j = {{11{i_data.instruction[31]}}, i_data.instruction[31],
                    i_data.instruction[19:12], i_data.instruction[20],
                    i_data.instruction[30:21], 1'b0};

    always_comb begin
        case (op)
            OP_BRANCH: kind = KIND_COND;
            OP_JAL:    kind = KIND_JAL;
            OP_JALR:   kind = KIND_JALR;
            default:   kind = KIND_NONE;
        endcase
    end

    assign o_dec.kind = kind;

    assign imm = (kind == KIND_COND) ? imm_b : imm_j;
    assign sum = {1'b0, i_data.pc} + {1'b0, imm};

    assign o_dec.taken  = i_data.next_pc != (i_data.pc + 32'd4);
    assign o_dec.target = (kind == KIND_COND || kind == KIND_JAL) ?
                          sum[31:0] : 32'd0;
    // target below pc exactly when the add carries out of bit 31
    assign o_dec.backward = sum[32];

    assign hist_x = 30'(r_hist);
    assign o_bi   = i_data.pc[2 +: BHT_W];
    assign o_gi   = PHT_W'(i_data.pc[31:2] ^ hist_x);

    assign n_hist = HISTORY_BITS'({r_hist, o_dec.taken});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
        end else if (i_accept && kind == KIND_COND) begin
            r_hist <= n_hist;
        end
    end

endmodule

`default_nettype wire

/* rtl/bpe_queue.sv */
// Two-entry queue between the decode front and the table back end.
// No dependencies.
`default_nettype none

module bpe_queue #(
    parameter int DATA_W = 40
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  wire  [DATA_W-1:0] i_data,
    output logic              o_full,
    input  wire               i_pop,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data
);

    logic [DATA_W-1:0] r_mem [2];
    logic [1:0]        r_cnt;
    logic [1:0]        n_cnt;
    logic              r_head;
    logic              wr_sel;
    logic              do_pop;

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_data  = r_mem[r_head];
    assign do_pop  = i_pop && o_valid;
    assign wr_sel  = r_head ^ r_cnt[0];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !do_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (do_pop && !i_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[wr_sel] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 2'd0;
            r_head <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (do_pop) begin
                r_head <= ~r_head;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/bpe_back.sv */
// Back end: predictor tables with read, predict and write-back, forwarding,
// the post-reset clearing sweep and the output register. Depends on bpe_pkg.
`default_nettype none

module bpe_back #(
    parameter int BHT_DEPTH = 256,
    parameter int PHT_DEPTH = 512,
    parameter int BHT_W     = 8,
    parameter int PHT_W     = 9
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_q_valid,
    input  bpe_pkg::t_dec     i_q_dec,
    input  wire  [BHT_W-1:0]  i_q_bi,
    input  wire  [PHT_W-1:0]  i_q_gi,
    output logic              o_q_pop,
    output logic              o_clr_busy,
    output logic              o_valid,
    input  wire               i_ready,
    output bpe_pkg::t_out     o_data
);
    import bpe_pkg::*;

    localparam int CLR_N = (BHT_DEPTH > PHT_DEPTH) ? BHT_DEPTH : PHT_DEPTH;
    localparam int CLR_W = $clog2(CLR_N);

    function automatic logic [1:0] counter_step(input logic [1:0] c, input logic up);
        logic [1:0] r;
        if (up) begin
            r = (c == 2'd3) ? 2'd3 : c + 2'd1;
        end else begin
            r = (c == 2'd0) ? 2'd0 : c - 2'd1;
        end
        return r;
    endfunction

    logic       mem_last [BHT_DEPTH];
    logic [1:0] mem_bim  [BHT_DEPTH];
    logic [1:0] mem_gsh  [PHT_DEPTH];

    logic             r_clr_busy;
    logic [CLR_W-1:0] r_clr_idx;
    logic             clr_bht;

    logic             r_rd_valid;
    t_dec             r_rd_dec;
    logic [BHT_W-1:0] r_rd_bi;
    logic [PHT_W-1:0] r_rd_gi;
    logic             r_rd_last;
    logic [1:0]       r_rd_bim;
    logic [1:0]       r_rd_gsh;

    logic             r_fwd_b;
    logic             r_fwd_g;
    logic             r_f_last;
    logic [1:0]       r_f_bim;
    logic [1:0]       r_f_gsh;

    logic             r_out_valid;
    t_out             r_out;
    t_out             n_out;

    logic             rd_adv;
    logic             upd;
    logic             cur_last;
    logic [1:0]       cur_bim;
    logic [1:0]       cur_gsh;
    logic             new_last;
    logic [1:0]       new_bim;
    logic [1:0]       new_gsh;
    logic [N_PRED-1:0] preds;

    assign rd_adv  = r_rd_valid && (!r_out_valid || i_ready);
    assign o_q_pop = i_q_valid && (!r_rd_valid || rd_adv);
    assign upd     = rd_adv && r_rd_dec.kind == KIND_COND;
    assign clr_bht = (BHT_DEPTH == CLR_N) ? 1'b1 : (r_clr_idx < CLR_W'(BHT_DEPTH));

    // a write on the same edge as the read leaves stale data: take the forwarded copy
    assign cur_last = r_fwd_b ? r_f_last : r_rd_last;
    assign cur_bim  = r_fwd_b ? r_f_bim  : r_rd_bim;
    assign cur_gsh  = r_fwd_g ? r_f_gsh  : r_rd_gsh;

    assign new_last = r_rd_dec.taken;
    assign new_bim  = counter_step(cur_bim, r_rd_dec.taken);
    assign new_gsh  = counter_step(cur_gsh, r_rd_dec.taken);

    assign preds = {cur_gsh[1], cur_bim[1], cur_last, r_rd_dec.backward, 1'b1, 1'b0};

    always_comb begin
        n_out.branch_kind     = r_rd_dec.kind;
        n_out.br_taken        = r_rd_dec.taken;
        n_out.branch_target   = r_rd_dec.target;
        n_out.prediction_mask = '0;
        n_out.correct_mask    = '0;
        if (r_rd_dec.kind == KIND_COND) begin
            n_out.prediction_mask = preds;
            n_out.correct_mask    = r_rd_dec.taken ? preds : ~preds;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy && clr_bht) begin
            mem_last[r_clr_idx[BHT_W-1:0]] <= 1'b0;
        end else if (upd) begin
            mem_last[r_rd_bi] <= new_last;
        end
        if (o_q_pop) begin
            r_rd_last <= mem_last[i_q_bi];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy && clr_bht) begin
            mem_bim[r_clr_idx[BHT_W-1:0]] <= 2'd1;
        end else if (upd) begin
            mem_bim[r_rd_bi] <= new_bim;
        end
        if (o_q_pop) begin
            r_rd_bim <= mem_bim[i_q_bi];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy && (PHT_DEPTH == CLR_N || r_clr_idx < CLR_W'(PHT_DEPTH))) begin
            mem_gsh[r_clr_idx[PHT_W-1:0]] <= 2'd1;
        end else if (upd) begin
            mem_gsh[r_rd_gi] <= new_gsh;
        end
        if (o_q_pop) begin
            r_rd_gsh <= mem_gsh[i_q_gi];
        end
    end

    // payload of the read stage, forwarding copies and the output register
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_rd_dec <= i_q_dec;
            r_rd_bi  <= i_q_bi;
            r_rd_gi  <= i_q_gi;
            r_f_last <= new_last;
            r_f_bim  <= new_bim;
            r_f_gsh  <= new_gsh;
        end
        if (rd_adv) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy  <= 1'b1;
            r_clr_idx   <= '0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_fwd_b     <= 1'b0;
            r_fwd_g     <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_idx <= r_clr_idx + CLR_W'(1);
                if (r_clr_idx == CLR_W'(CLR_N - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (o_q_pop) begin
                r_rd_valid <= 1'b1;
                r_fwd_b    <= upd && r_rd_bi == i_q_bi;
                r_fwd_g    <= upd && r_rd_gi == i_q_gi;
            end else if (rd_adv) begin
                r_rd_valid <= 1'b0;
            end
            if (rd_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_clr_busy = r_clr_busy;
    assign o_valid    = r_out_valid;
    assign o_data     = r_out;

endmodule

`default_nettype wire

/* rtl/branch_predictor_evaluator_top.sv */
// Branch predictor evaluator top level: front decode, queue, table back end.
// Depends on bpe_pkg, bpe_front, bpe_queue and bpe_back.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------
//  input   | in        | i_valid / o_ready  | i_data (t_in)
//  result  | out       | o_valid / i_ready  | o_data (t_out)
//
// One beat per cycle sustained while the result side is ready; an accepted beat
// goes through the queue, table read and output register before o_valid rises.
// Table read-modify-write forwards between back-to-back beats to the same entry.
// After reset a clearing sweep over max(BHT_DEPTH, PHT_DEPTH) indices (512 by
// default) writes the tables; o_ready stays low meanwhile. A stalled output
// holds the back end; the two-entry queue lets the front accept until full.
// BHT_DEPTH and PHT_DEPTH must be powers of two; the block does not check it.
`default_nettype none

module branch_predictor_evaluator_top #(
    parameter int BHT_DEPTH    = 256,
    parameter int PHT_DEPTH    = 512,
    parameter int HISTORY_BITS = 9
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_valid,
    output logic           o_ready,
    input  bpe_pkg::t_in   i_data,
    output logic           o_valid,
    input  wire            i_ready,
    output bpe_pkg::t_out  o_data
);
    import bpe_pkg::*;

    localparam int BHT_W  = $clog2(BHT_DEPTH);
    localparam int PHT_W  = $clog2(PHT_DEPTH);
    localparam int DEC_W  = $bits(t_dec);
    localparam int ITEM_W = DEC_W + BHT_W + PHT_W;

    t_dec              f_dec;
    logic [BHT_W-1:0]  f_bi;
    logic [PHT_W-1:0]  f_gi;
    logic              accept;
    logic              q_full;
    logic              q_valid;
    logic              q_pop;
    logic [ITEM_W-1:0] q_head;
    logic              clr_busy;
    t_dec              q_dec;
    logic [BHT_W-1:0]  q_bi;
    logic [PHT_W-1:0]  q_gi;

    assign o_ready = !q_full && !clr_busy;
    assign accept  = i_valid && o_ready;

    bpe_front #(
        .BHT_W        (BHT_W),
        .PHT_W        (PHT_W),
        .HISTORY_BITS (HISTORY_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_data   (i_data),
        .o_dec    (f_dec),
        .o_bi     (f_bi),
        .o_gi     (f_gi)
    );

    bpe_queue #(
        .DATA_W (ITEM_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  ({f_dec, f_bi, f_gi}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_head)
    );

    assign q_dec = q_head[ITEM_W-1 -: DEC_W];
    assign q_bi  = q_head[PHT_W +: BHT_W];
    assign q_gi  = q_head[PHT_W-1:0];

    bpe_back #(
        .BHT_DEPTH (BHT_DEPTH),
        .PHT_DEPTH (PHT_DEPTH),
        .BHT_W     (BHT_W),
        .PHT_W     (PHT_W)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_dec    (q_dec),
        .i_q_bi     (q_bi),
        .i_q_gi     (q_gi),
        .o_q_pop    (q_pop),
        .o_clr_busy (clr_busy),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data)
    );

endmodule

`default_nettype wire

/* rtl/bpe_checker.sv */
// Port-level checks for the branch predictor evaluator, bound to the top.
// Depends on bpe_pkg and branch_predictor_evaluator_top.
`default_nettype none

module bpe_checker (
    input wire            i_clk,
    input wire            i_rst_n,
    input wire            o_valid,
    input wire            i_ready,
    input bpe_pkg::t_out  o_data
);
    import bpe_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result beat changed while stalled");

    a_no_pred: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.branch_kind != KIND_COND |->
        o_data.prediction_mask == '0 && o_data.correct_mask == '0)
        else $error("predictions on a non-conditional beat");

    a_fixed_pred: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.branch_kind == KIND_COND |->
        o_data.prediction_mask[1] && !o_data.prediction_mask[0])
        else $error("never/always predictors wrong");

    a_correct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.branch_kind == KIND_COND |->
        o_data.correct_mask == (o_data.br_taken ? o_data.prediction_mask
                                                : ~o_data.prediction_mask))
        else $error("correct mask disagrees with outcome");

    a_jalr_tgt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.branch_kind == KIND_JALR || o_data.branch_kind == KIND_NONE)
        |-> o_data.branch_target == 32'd0)
        else $error("target set on jalr or non-branch");

endmodule

bind branch_predictor_evaluator_top bpe_checker u_bpe_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);

`default_nettype wire

/* verif/branch_predictor_evaluator_checker.sv */
`timescale 1ns / 100ps
// Checker for the branch predictor evaluator: watches both channels, scores each
// input beat against its own copy of the predictor tables and compares results.
// Depends on bpe_pkg for the payload types, opcodes and kind codes.

module branch_predictor_evaluator_checker #(
    parameter int BHT_DEPTH    = 256,
    parameter int PHT_DEPTH    = 512,
    parameter int HISTORY_BITS = 9
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    input  wire            i_in_ready,
    input  bpe_pkg::t_in   i_in_data,
    input  wire            i_out_valid,
    input  wire            i_out_ready,
    input  bpe_pkg::t_out  i_out_data,
    output int             o_errors,
    output int             o_pending
);
    import bpe_pkg::*;

    logic                    last_taken [BHT_DEPTH];
    logic [1:0]              bimodal    [BHT_DEPTH];
    logic [1:0]              gshare     [PHT_DEPTH];
    logic [HISTORY_BITS-1:0] ghist;

    t_out verdict_q [$];

    function automatic logic [1:0] sat_step(input logic [1:0] c, input logic up);
        if (up)
            return (c == 2'd3) ? c : c + 2'd1;
        return (c == 2'd0) ? c : c - 2'd1;
    endfunction

    // Score one executed instruction and, for a conditional branch, train the tables on its outcome
    function automatic t_out evaluate_branch(input t_in b);
        t_out        r;
        logic [31:0] ins;
        logic [31:0] offset;
        int unsigned bi;
        int unsigned gi;
        ins = b.instruction;
        r = '0;
        r.br_taken = (b.next_pc != b.pc + 32'd4);
        case (ins[6:0])
            OP_BRANCH: r.branch_kind = KIND_COND;
            OP_JAL:    r.branch_kind = KIND_JAL;
            OP_JALR:   r.branch_kind = KIND_JALR;
            default:   r.branch_kind = KIND_NONE;
        endcase
        if (r.branch_kind == KIND_JAL) begin
            offset = {{12{ins[31]}}, ins[19:12], ins[20], ins[30:21], 1'b0};
            r.branch_target = b.pc + offset;
        end
        if (r.branch_kind == KIND_COND) begin
            offset = {{20{ins[31]}}, ins[7], ins[30:25], ins[11:8], 1'b0};
            r.branch_target = b.pc + offset;
            bi = (b.pc >> 2) % BHT_DEPTH;
            gi = ((b.pc >> 2) ^ 32'(ghist)) % PHT_DEPTH;
            r.prediction_mask[1] = 1'b1;
            r.prediction_mask[2] = r.branch_target < b.pc;
            r.prediction_mask[3] = last_taken[bi];
            r.prediction_mask[4] = bimodal[bi][1];
            r.prediction_mask[5] = gshare[gi][1];
            r.correct_mask = r.br_taken ? r.prediction_mask : ~r.prediction_mask;
            last_taken[bi] = r.br_taken;
            bimodal[bi] = sat_step(bimodal[bi], r.br_taken);
            gshare[gi] = sat_step(gshare[gi], r.br_taken);
            ghist = {ghist[HISTORY_BITS-2:0], r.br_taken};
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            o_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            foreach (last_taken[k]) last_taken[k] = 1'b0;
            foreach (bimodal[k]) bimodal[k] = 2'd1;
            foreach (gshare[k]) gshare[k] = 2'd1;
            ghist = '0;
            verdict_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (verdict_q.size() == 0) begin
                    $error("result beat with nothing outstanding: 0x%0h", i_out_data);
                    o_errors++;
                end else begin
                    want = verdict_q.pop_front();
                    check_field("branch_kind", 32'(want.branch_kind),
                                32'(i_out_data.branch_kind));
                    check_field("br_taken", 32'(want.br_taken),
                                32'(i_out_data.br_taken));
                    check_field("branch_target", want.branch_target,
                                i_out_data.branch_target);
                    check_field("prediction_mask", 32'(want.prediction_mask),
                                32'(i_out_data.prediction_mask));
                    check_field("correct_mask", 32'(want.correct_mask),
                                32'(i_out_data.correct_mask));
                end
            end
            if (i_in_valid && i_in_ready)
                verdict_q.push_back(evaluate_branch(i_in_data));
        end
        o_pending = verdict_q.size();
    end

endmodule

/* verif/branch_predictor_evaluator_top_test.sv */
`timescale 1ns / 100ps
// Testbench top for the branch predictor evaluator: clock, reset, stimulus and verdict.
// Depends on bpe_pkg, branch_predictor_evaluator_top and branch_predictor_evaluator_checker.

module branch_predictor_evaluator_top_test;
    import bpe_pkg::*;

    localparam int N_RANDOM    = 1650;
    localparam int N_SITES     = 16;
    localparam int HOLD_CYCLES = 400;

    typedef enum {MOSTLY_TAKEN, MOSTLY_NOT, LOOP_EXIT, COIN_FLIP} t_habit;

    typedef struct {
        logic [31:0] pc;
        logic [31:0] offset;
        logic [31:0] ins;
        t_habit      habit;
        int          period;
        int          count;
    } t_site;

    logic i_clk;
    logic i_rst_n;
    logic in_valid;
    logic in_ready;
    t_in  in_beat;
    logic out_valid;
    logic out_ready;
    t_out out_beat;
    int   errors;
    int   pending;

    logic quiet    = 1'b0;
    logic hold_req = 1'b0;
    int   n_cond   = 0;
    int   n_jump   = 0;
    int   n_other  = 0;

    t_site sites [N_SITES];
    int    last_site = 0;

    branch_predictor_evaluator_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_valid),
        .o_ready (in_ready),
        .i_data  (in_beat),
        .o_valid (out_valid),
        .i_ready (out_ready),
        .o_data  (out_beat)
    );

    branch_predictor_evaluator_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_beat),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_beat),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Result side: random stalls, a quiet stretch and one long hold-off
    initial begin
        out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                out_ready <= quiet || ($urandom_range(99) >= 38);
            end
        end
    end

    function automatic logic [31:0] enc_branch(input logic [12:0] off);
        logic [31:0] r;
        r = $urandom;
        return {off[12], off[10:5], r[24:20], r[19:15], r[14:12], off[4:1], off[11], OP_BRANCH};
    endfunction

    function automatic logic [31:0] enc_jal(input logic [20:0] off);
        logic [31:0] r;
        r = $urandom;
        return {off[20], off[10:1], off[11], off[19:12], r[11:7], OP_JAL};
    endfunction

    function automatic t_site make_site();
        t_site s;
        logic [12:0] off;
        if ($urandom_range(99) < 70)
            s.pc = 32'h0001_0000 + ($urandom_range(0, 511) << 2);
        else
            s.pc = $urandom & 32'hFFFF_FFFC;
        // mostly short backward loops, some arbitrary offsets
        if ($urandom_range(99) < 60)
            off = -13'($urandom_range(1, 64) * 2);
        else
            off = 13'($urandom) & 13'h1FFE;
        s.offset = {{19{off[12]}}, off};
        s.ins    = enc_branch(off);
        s.habit  = t_habit'($urandom_range(0, 3));
        s.period = $urandom_range(2, 9);
        s.count  = 0;
        return s;
    endfunction

    task automatic send_beat(input logic [31:0] pc, input logic [31:0] ins,
                             input logic [31:0] npc);
        case (ins[6:0])
            OP_BRANCH:      n_cond++;
            OP_JAL, OP_JALR: n_jump++;
            default:        n_other++;
        endcase
        if (!quiet && $urandom_range(99) < 38) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge i_clk);
        end
        in_beat  <= '{pc: pc, instruction: ins, next_pc: npc};
        in_valid <= 1'b1;
        do @(posedge i_clk); while (!in_ready);
    endtask

    // Mostly branch sites with habits the predictors can learn, plus jumps and noise
    task automatic send_random_beat();
        int          sel;
        int          s;
        logic        taken;
        logic [31:0] pc;
        logic [31:0] ins;
        logic [31:0] npc;
        logic [20:0] joff;
        sel = $urandom_range(99);
        if (sel < 62) begin
            s = ($urandom_range(99) < 30) ? last_site : $urandom_range(0, N_SITES - 1);
            if ($urandom_range(99) < 4)
                sites[s] = make_site();
            last_site = s;
            case (sites[s].habit)
                MOSTLY_TAKEN: taken = $urandom_range(99) < 85;
                MOSTLY_NOT:   taken = $urandom_range(99) < 15;
                LOOP_EXIT: begin
                    sites[s].count++;
                    taken = sites[s].count % sites[s].period != 0;
                end
                default:      taken = 1'($urandom_range(1));
            endcase
            pc  = sites[s].pc;
            ins = sites[s].ins;
            npc = taken ? pc + sites[s].offset : pc + 32'd4;
            if (taken && $urandom_range(99) < 10)
                npc = $urandom;
        end else if (sel < 72) begin
            joff = 21'($urandom) & 21'h1F_FFFE;
            pc   = $urandom & 32'hFFFF_FFFC;
            ins  = enc_jal(joff);
            npc  = pc + {{11{joff[20]}}, joff};
        end else if (sel < 79) begin
            pc  = $urandom;
            ins = {25'($urandom_range(0, 32'h01FF_FFFF)), OP_JALR};
            npc = ($urandom_range(99) < 20) ? pc + 32'd4 : $urandom;
        end else if (sel < 86) begin
            pc  = $urandom;
            ins = $urandom;
            if (ins[6:0] == OP_BRANCH || ins[6:0] == OP_JAL || ins[6:0] == OP_JALR)
                ins[6:0] = 7'h13;
            npc = ($urandom_range(99) < 80) ? pc + 32'd4 : $urandom;
        end else begin
            pc  = $urandom;
            ins = $urandom;
            npc = $urandom;
        end
        send_beat(pc, ins, npc);
    endtask

    initial begin
        i_rst_n  = 1'b0;
        in_valid = 1'b0;
        in_beat  = '0;
        foreach (sites[k]) sites[k] = make_site();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // plain ALU op, all-ones and all-zeros words
        send_beat(32'h0000_0100, 32'h0000_0033, 32'h0000_0104);
        send_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_beat(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        // jumps at both ends of the offset range, jalr taken and falling through
        send_beat(32'h0000_1000, enc_jal(21'h0F_FFFE), 32'h0010_0FFE);
        send_beat(32'h0000_0000, enc_jal(21'h10_0000), 32'hFFF0_0000);
        send_beat(32'h0000_2000, 32'h0000_8067, 32'h1234_5678);
        send_beat(32'h0000_2004, 32'hFFFF_FFE7, 32'h0000_2008);
        // branch offsets at the extremes, with wrap of target and of pc + 4
        send_beat(32'hFFFF_FFF0, enc_branch(13'h0FFE), 32'h0000_0FEE);
        send_beat(32'h0000_0000, enc_branch(13'h1000), 32'h0000_0004);
        send_beat(32'hFFFF_FFFC, enc_branch(13'h0008), 32'h0000_0000);
        // repeated hits on one entry: saturate up, then count back down to zero
        repeat (4) send_beat(32'h0000_0400, enc_branch(13'h1FF0), 32'h0000_03F0);
        repeat (3) send_beat(32'h0000_0400, enc_branch(13'h1FF0), 32'h0000_0404);
        // same table entry from another pc, then a zero offset taken
        send_beat(32'h0000_0800, enc_branch(13'h0040), 32'h0000_0840);
        send_beat(32'h0000_0010, enc_branch(13'h0000), 32'h0000_0010);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 400)
                hold_req = 1'b1;
            quiet = (n >= 900 && n < 1150);
            send_random_beat();
        end
        in_valid <= 1'b0;

        // let the checker take in the last beat before watching the count
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        $display("Scored %0d beats: %0d conditional branches, %0d jumps, %0d other words,",
                 n_cond + n_jump + n_other, n_cond, n_jump, n_other);
        $display("with random stalls on both sides and a %0d-cycle result hold-off",
                 HOLD_CYCLES);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* filelist.f */
rtl/bpe_pkg.sv
rtl/bpe_front.sv
rtl/bpe_queue.sv
rtl/bpe_back.sv
rtl/branch_predictor_evaluator_top.sv
rtl/bpe_checker.sv
verif/branch_predictor_evaluator_checker.sv
verif/branch_predictor_evaluator_top_test.sv
